### sv/kmpq_pkg.sv
// Shared constants, codes and types for the keyed max-priority queue.
// Used by the controller, the datapath, the top level and the checker.
package kmpq_pkg;

    localparam int ENTRIES       = 64;
    localparam int KEY_BITS      = 16;
    localparam int PRIORITY_BITS = 32;

    localparam int KEY_PORT_W  = 16;
    localparam int PRIO_PORT_W = 32;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W       = $clog2(ENTRIES + 1);
    localparam int SLOT_W      = KEY_BITS + PRIORITY_BITS;

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_SET_OK   = 2'd0,
        ST_SET_FULL = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted word, clear the sweep
        logic read;    // issue one slot read and advance the sweep
        logic commit;  // update the store and load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // sweep index sits on the last slot
        logic out_free;   // result register can take a word this cycle
    } dp_status_t;

    function automatic logic [KEY_BITS-1:0] key_from_port(input logic [KEY_PORT_W-1:0] k);
        logic [KEY_BITS+KEY_PORT_W-1:0] t;
        t = {{KEY_BITS{1'b0}}, k};
        return t[KEY_BITS-1:0];
    endfunction

    function automatic logic [KEY_PORT_W-1:0] key_to_port(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS+KEY_PORT_W-1:0] t;
        t = {{KEY_PORT_W{1'b0}}, k};
        return t[KEY_PORT_W-1:0];
    endfunction

    function automatic logic [PRIORITY_BITS-1:0] prio_from_port(
        input logic [PRIO_PORT_W-1:0] p);
        logic [PRIORITY_BITS+PRIO_PORT_W-1:0] t;
        t = {{PRIORITY_BITS{p[PRIO_PORT_W-1]}}, p};
        return t[PRIORITY_BITS-1:0];
    endfunction

    function automatic logic [PRIO_PORT_W-1:0] prio_to_port(
        input logic [PRIORITY_BITS-1:0] p);
        logic [PRIORITY_BITS+PRIO_PORT_W-1:0] t;
        t = {{PRIO_PORT_W{p[PRIORITY_BITS-1]}}, p};
        return t[PRIO_PORT_W-1:0];
    endfunction

endpackage

### sv/keyed_max_priority_queue.sv
// Keyed max-priority queue: top level joining the sequencer and the datapath.
// Depends on kmpq_pkg, kmpq_ctrl, kmpq_dpath (and kmpq_ram below it).
//
// Usage
//   Item channel (item_valid / item_stall): one word carries kind, key and
//   priority_req. kind set inserts the key or replaces its priority; kind pop
//   removes the entry of highest priority, the lowest key winning a tie.
//   Result channel (result_valid / result_stall): exactly one word per item,
//   with status (set accepted, set dropped because the store is full, popped,
//   queue empty) and, for a pop, the removed key and priority; otherwise zero.
// Timing
//   An item sweeps every slot of the store through one RAM read port, one slot
//   a cycle; a drain state and a commit state follow before the result is
//   loaded. Only one item is in flight; item_stall is high from acceptance
//   until the result has been loaded into the result register.
// Reset
//   rst_n (asynchronous, active low) empties the queue at once; no clearing
//   pass follows; the sweep ignores the contents of a slot whose valid bit is clear.
// Back-pressure
//   While result_stall is high the result word holds. The block still sweeps
//   the next item and waits before its commit until the result register frees.
module keyed_max_priority_queue (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic                                    kind,
    input  logic [kmpq_pkg::KEY_PORT_W-1:0]         key,
    input  logic signed [kmpq_pkg::PRIO_PORT_W-1:0] priority_req,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic [1:0]                              status,
    output logic [kmpq_pkg::KEY_PORT_W-1:0]         popped_key,
    output logic signed [kmpq_pkg::PRIO_PORT_W-1:0] popped_priority
);
    import kmpq_pkg::*;

    // command and status between sequencer and datapath
    cmd_t       cmd;
    dp_status_t dp_stat;

    kmpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_stat    (dp_stat),
        .cmd        (cmd)
    );

    kmpq_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_stat         (dp_stat),
        .kind            (kind),
        .key             (key),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .popped_key      (popped_key),
        .popped_priority (popped_priority)
    );

endmodule

### sv/kmpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wen,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      ren,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/kmpq_ctrl.sv
// Sequencer for the keyed max-priority queue: accept, sweep, commit.
// Depends on kmpq_pkg.
module kmpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  kmpq_pkg::dp_status_t dp_stat,
    output kmpq_pkg::cmd_t      cmd
);
    import kmpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.read = 1'b1;
                if (dp_stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the result register is free
                if (dp_stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/kmpq_dpath.sv
// Datapath of the keyed max-priority queue: slot store, sweep, result register.
// Depends on kmpq_pkg and kmpq_ram.
module kmpq_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kmpq_pkg::cmd_t                       cmd,
    output kmpq_pkg::dp_status_t                 dp_stat,
    input  logic                                 kind,
    input  logic [kmpq_pkg::KEY_PORT_W-1:0]      key,
    input  logic signed [kmpq_pkg::PRIO_PORT_W-1:0] priority_req,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [1:0]                           status,
    output logic [kmpq_pkg::KEY_PORT_W-1:0]      popped_key,
    output logic signed [kmpq_pkg::PRIO_PORT_W-1:0] popped_priority
);
    import kmpq_pkg::*;

    // captured word
    logic                            kind_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic signed [PRIORITY_BITS-1:0] prio_reg;

    // sweep
    logic [IDX_W-1:0] scan_reg;
    logic             rd_live_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // store state
    logic [ENTRIES-1:0] slot_valid_reg;
    logic [OCC_W-1:0]   occ_reg;

    // sweep results
    logic                            match_found_reg;
    logic [IDX_W-1:0]                match_idx_reg;
    logic                            free_found_reg;
    logic [IDX_W-1:0]                free_idx_reg;
    logic                            best_found_reg;
    logic [IDX_W-1:0]                best_idx_reg;
    logic [KEY_BITS-1:0]             best_key_reg;
    logic signed [PRIORITY_BITS-1:0] best_prio_reg;

    // result register
    logic                            res_valid_reg;
    status_t                         res_status_reg;
    logic [KEY_PORT_W-1:0]           res_key_reg;
    logic signed [PRIO_PORT_W-1:0]   res_prio_reg;

    logic                            ram_wen;
    logic [IDX_W-1:0]                ram_waddr;
    logic [SLOT_W-1:0]               ram_rdata;
    logic [KEY_BITS-1:0]             rd_key;
    logic signed [PRIORITY_BITS-1:0] rd_prio;
    logic                            rd_held;
    logic                            rd_better;
    logic                            is_pop;
    logic                            full;
    logic                            set_ok;
    status_t                         status_next;

    kmpq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata ({key_reg, prio_reg}),
        .ren   (cmd.read),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[SLOT_W-1:PRIORITY_BITS];
    assign rd_prio = signed'(ram_rdata[PRIORITY_BITS-1:0]);
    assign rd_held = rd_live_reg && slot_valid_reg[rd_idx_reg];

    // higher priority wins, equal priority goes to the lower key
    assign rd_better = !best_found_reg || (rd_prio > best_prio_reg)
                       || ((rd_prio == best_prio_reg) && (rd_key < best_key_reg));

    assign is_pop = (kind_reg == KIND_POP);
    assign full   = (occ_reg == OCC_W'(ENTRIES));
    assign set_ok = match_found_reg || !full;

    assign ram_wen   = cmd.commit && !is_pop && set_ok;
    assign ram_waddr = match_found_reg ? match_idx_reg : free_idx_reg;

    always_comb
    begin
        if (is_pop)
        begin
            status_next = best_found_reg ? ST_POPPED : ST_EMPTY;
        end
        else
        begin
            status_next = set_ok ? ST_SET_OK : ST_SET_FULL;
        end
    end

    assign dp_stat.scan_last = (scan_reg == IDX_W'(ENTRIES - 1));
    assign dp_stat.out_free  = !res_valid_reg || !result_stall;

    assign result_valid    = res_valid_reg;
    assign status          = res_status_reg;
    assign popped_key      = res_key_reg;
    assign popped_priority = res_prio_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg     <= 1'b0;
            slot_valid_reg  <= '0;
            occ_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.read;

            if (cmd.load)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            else if (rd_live_reg)
            begin
                if (rd_held && (rd_key == key_reg))
                begin
                    match_found_reg <= 1'b1;
                end
                if (!slot_valid_reg[rd_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
                if (rd_held && rd_better)
                begin
                    best_found_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                if (is_pop && best_found_reg)
                begin
                    slot_valid_reg[best_idx_reg] <= 1'b0;
                    occ_reg <= occ_reg - OCC_W'(1);
                end
                else if (!is_pop && !match_found_reg && !full)
                begin
                    slot_valid_reg[free_idx_reg] <= 1'b1;
                    occ_reg <= occ_reg + OCC_W'(1);
                end
            end

            if (cmd.commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= key_from_port(key);
            prio_reg <= signed'(prio_from_port(priority_req));
            scan_reg <= '0;
        end
        else if (cmd.read)
        begin
            scan_reg <= scan_reg + IDX_W'(1);
        end

        if (cmd.read)
        begin
            rd_idx_reg <= scan_reg;
        end

        if (rd_live_reg)
        begin
            if (rd_held && (rd_key == key_reg) && !match_found_reg)
            begin
                match_idx_reg <= rd_idx_reg;
            end
            if (!slot_valid_reg[rd_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_held && rd_better)
            begin
                best_idx_reg  <= rd_idx_reg;
                best_key_reg  <= rd_key;
                best_prio_reg <= rd_prio;
            end
        end

        if (cmd.commit)
        begin
            res_status_reg <= status_next;
            if (status_next == ST_POPPED)
            begin
                res_key_reg  <= key_to_port(best_key_reg);
                res_prio_reg <= signed'(prio_to_port(best_prio_reg));
            end
            else
            begin
                res_key_reg  <= '0;
                res_prio_reg <= '0;
            end
        end
    end

endmodule

### sv/kmpq_checker.sv
// Port-level checks for the keyed max-priority queue, bound to the top level.
// Depends on kmpq_pkg.
module kmpq_props (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    item_valid,
    input logic                                    item_stall,
    input logic                                    result_valid,
    input logic                                    result_stall,
    input logic [1:0]                              status,
    input logic [kmpq_pkg::KEY_PORT_W-1:0]         popped_key,
    input logic signed [kmpq_pkg::PRIO_PORT_W-1:0] popped_priority
);
    import kmpq_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(popped_key)
            && $stable(popped_priority))
        else $error("stalled result word changed");

    // fields without meaning are zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_POPPED) |->
            (popped_key == '0) && (popped_priority == '0))
        else $error("pop fields not zero on a non-pop result");

    // one item at a time: stall straight after acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second word taken while an item is in flight");

    // a full sweep lies between acceptance and commit, so no fresh result right after acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##1 !$rose(result_valid))
        else $error("result appeared one cycle after acceptance");

endmodule

bind keyed_max_priority_queue kmpq_props u_kmpq_props (.*);

### tb/kmpq_checker.sv
`timescale 1ns / 1ps
// Checker for keyed_max_priority_queue: watches both channels, keeps its own image of the queue,
// predicts each result word and compares it field by field. Depends on kmpq_pkg.
module kmpq_checker
    import kmpq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic                          kind,
    input  logic [KEY_PORT_W-1:0]         key,
    input  logic signed [PRIO_PORT_W-1:0] priority_req,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [1:0]                    status,
    input  logic [KEY_PORT_W-1:0]         popped_key,
    input  logic signed [PRIO_PORT_W-1:0] popped_priority,
    output int                            fail_count,
    output int                            results_due
);

    typedef struct {
        status_t                       st;
        logic [KEY_PORT_W-1:0]         k;
        logic signed [PRIO_PORT_W-1:0] p;
    } outcome_t;

    outcome_t due_results[$];

    logic [KEY_BITS-1:0]             held_key  [ENTRIES];
    logic signed [PRIORITY_BITS-1:0] held_prio [ENTRIES];
    logic                            held      [ENTRIES];

    // Apply one accepted word to the queue image and return the word it must produce.
    function automatic outcome_t serve_item(input logic                          k_kind,
                                            input logic [KEY_PORT_W-1:0]         k_in,
                                            input logic signed [PRIO_PORT_W-1:0] p_in);
        outcome_t                        o;
        logic [KEY_BITS-1:0]             k;
        logic signed [PRIORITY_BITS-1:0] p;
        int                              slot;
        o.st = ST_SET_OK;
        o.k  = '0;
        o.p  = '0;
        slot = -1;
        k    = KEY_BITS'(k_in);
        p    = PRIORITY_BITS'(p_in);
        if (k_kind == KIND_SET)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && held[i] && held_key[i] == k)
                    slot = i;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !held[i])
                    slot = i;
            if (slot < 0)
                o.st = ST_SET_FULL;
            else
            begin
                held[slot]      = 1'b1;
                held_key[slot]  = k;
                held_prio[slot] = p;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (held[i] && (slot < 0 || held_prio[i] > held_prio[slot]
                    || (held_prio[i] == held_prio[slot] && held_key[i] < held_key[slot])))
                    slot = i;
            if (slot < 0)
                o.st = ST_EMPTY;
            else
            begin
                o.st       = ST_POPPED;
                o.k        = KEY_PORT_W'(held_key[slot]);
                o.p        = PRIO_PORT_W'(held_prio[slot]);
                held[slot] = 1'b0;
            end
        end
        return o;
    endfunction

    initial
    begin
        fail_count  = 0;
        results_due = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                held[i] = 1'b0;
            due_results.delete();
        end
        else
        begin
            // Check the outgoing word first: it belongs to an earlier item.
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result word: status %0d", status);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.st)
                    begin
                        fail_count++;
                        $error("status: expected %0d, actual %0d", want.st, status);
                    end
                    if (popped_key !== want.k)
                    begin
                        fail_count++;
                        $error("popped_key: expected %0h, actual %0h", want.k, popped_key);
                    end
                    if (popped_priority !== want.p)
                    begin
                        fail_count++;
                        $error("popped_priority: expected %0d, actual %0d",
                               want.p, popped_priority);
                    end
                end
            end
            if (item_valid && !item_stall)
                due_results.push_back(serve_item(kind, key, priority_req));
        end
        results_due = due_results.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the keyed max-priority queue testbench: clock, reset, stimulus and verdict.
// Depends on kmpq_pkg, keyed_max_priority_queue and kmpq_checker.
module tb_top;
    import kmpq_pkg::*;

    // The longest quiet stretch in a correct run is the receiver hold-off, so
    // keep the watchdog well above it.
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = ENTRIES + 16;
    localparam int BURSTS_PER_PASS = 12;
    localparam int WORDS_PER_BURST = 38;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    logic                          kind;
    logic [KEY_PORT_W-1:0]         key;
    logic signed [PRIO_PORT_W-1:0] priority_req;
    logic                          result_valid;
    logic                          result_stall;
    logic [1:0]                    status;
    logic [KEY_PORT_W-1:0]         popped_key;
    logic signed [PRIO_PORT_W-1:0] popped_priority;

    int   fail_count;
    int   results_due;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   quiet_cycles;
    logic hold_pending;

    keyed_max_priority_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .key             (key),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .popped_key      (popped_key),
        .popped_priority (popped_priority)
    );

    kmpq_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .key             (key),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .popped_key      (popped_key),
        .popped_priority (popped_priority),
        .fail_count      (fail_count),
        .results_due     (results_due)
    );

    // 8 ns period, low half first.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Offer one word. Call at a falling edge; return at the falling edge after
    // the word was taken. Idle cycles drop valid before the word goes out, and
    // each falling edge sees a single update of item_valid.
    task automatic offer(input logic                          w_kind,
                         input logic [KEY_PORT_W-1:0]         w_key,
                         input logic signed [PRIO_PORT_W-1:0] w_prio);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= w_kind;
        key          <= w_key;
        priority_req <= w_prio;
        // Hold the word until a rising edge finds the input not stalled.
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: stall at random, and once hold off for a long stretch so the
    // block backs up and stalls its own input.
    initial
    begin
        logic hold_taken;
        hold_taken   = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
                result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                            mode;
        int                            roll;
        int                            set_pct;
        logic                          is_pop;
        logic [KEY_PORT_W-1:0]         rkey;
        logic signed [PRIO_PORT_W-1:0] rprio;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        kind         = KIND_SET;
        key          = '0;
        priority_req = '0;
        tx_idle_pct  = 16;
        rx_idle_pct  = 85;
        hold_pending = 1'b0;
        quiet_cycles = 0;

        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words. Pop with nothing held.
        offer(KIND_POP, '0, '0);
        // Extreme keys and priorities, then two equal priorities on different keys.
        offer(KIND_SET, 16'h0000, 32'h7FFF_FFFF);
        offer(KIND_SET, 16'hFFFF, 32'h8000_0000);
        offer(KIND_SET, 16'h5555, 32'hFFFF_FFFF);
        offer(KIND_SET, 16'hAAAA, 32'hFFFF_FFFF);
        // Raise a held key to the top: replaced in place, tying with key zero.
        offer(KIND_SET, 16'h5555, 32'h7FFF_FFFF);
        // Drain: the lower key wins each tie, the most negative priority comes last.
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '1, '1);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        // Alternating priority patterns; lower a held key into a tie with a higher key.
        offer(KIND_SET, 16'h0007, 32'h5555_5555);
        offer(KIND_SET, 16'h0003, 32'h5555_5555);
        offer(KIND_SET, 16'h0005, 32'hAAAA_AAAA);
        offer(KIND_SET, 16'h0003, 32'hAAAA_AAAA);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        offer(KIND_POP, '0, '0);
        // A zero priority must still come back as a popped word.
        offer(KIND_SET, 16'h1234, 32'h0000_0000);
        offer(KIND_POP, '0, '0);

        // Random words in three passes: sender lightly idle with receiver mostly
        // stalled, then the reverse, then no idling with one long hold-off.
        for (int pass = 0; pass < 3; pass++)
        begin
            tx_idle_pct <= (pass == 0) ? 16 : (pass == 1) ? 85 : 0;
            rx_idle_pct <= (pass == 0) ? 85 : (pass == 1) ? 16 : 0;
            if (pass == 2)
                hold_pending <= 1'b1;
            repeat (BURSTS_PER_PASS)
            begin
                // Each burst leans to filling, draining or a mix, so the store
                // reaches full and empty again and again.
                mode    = $urandom_range(99);
                set_pct = (mode < 40) ? 85 : (mode < 65) ? 25 : 55;
                repeat (WORDS_PER_BURST)
                begin
                    is_pop = ($urandom_range(99) >= set_pct);
                    // Keys: mostly a pool of 96 spread over all bits so that
                    // held keys are hit, some fully random, some tiny for ties.
                    roll = $urandom_range(99);
                    if (roll < 60)
                        rkey = KEY_PORT_W'($urandom_range(95) * 40503);
                    else if (roll < 85)
                        rkey = KEY_PORT_W'($urandom);
                    else
                        rkey = KEY_PORT_W'($urandom_range(7));
                    roll = $urandom_range(99);
                    if (roll < 30)
                        rprio = int'($urandom_range(6)) - 3;
                    else if (roll < 45)
                    begin
                        case ($urandom_range(3))
                            0:       rprio = 32'h7FFF_FFFF;
                            1:       rprio = 32'h8000_0000;
                            2:       rprio = '0;
                            default: rprio = '1;
                        endcase
                    end
                    else
                        rprio = $urandom;
                    offer(is_pop ? KIND_POP : KIND_SET, rkey, rprio);
                end
            end
        end
        item_valid <= 1'b0;

        // Wait for every outstanding word, then watch a little longer for strays.
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
